### design/uhd_pkg.sv
// Shared types, codes and constants of the UPS HID report decoder.
package uhd_pkg;

    // Report identifiers that the decoder knows.
    localparam logic [7:0] ID_PRESENT  = 8'h06;
    localparam logic [7:0] ID_BATTERY  = 8'h0C;
    localparam logic [7:0] ID_UTILITY  = 8'h13;
    localparam logic [7:0] ID_OUT_VOLT = 8'h14;
    localparam logic [7:0] ID_FLAGS    = 8'h16;
    localparam logic [7:0] ID_IN_VOLT  = 8'h21;

    // Minimum report lengths, id byte included.
    localparam logic [6:0] LEN_PRESENT  = 7'd4;
    localparam logic [6:0] LEN_BATTERY  = 7'd4;
    localparam logic [6:0] LEN_UTILITY  = 7'd2;
    localparam logic [6:0] LEN_OUT_VOLT = 7'd3;
    localparam logic [6:0] LEN_FLAGS    = 7'd5;
    localparam logic [6:0] LEN_IN_VOLT  = 7'd2;

    // Bit positions in the valid mask.
    localparam int VM_CHARGE  = 0;
    localparam int VM_RUNTIME = 1;
    localparam int VM_BATTV   = 2;
    localparam int VM_UTIL    = 3;
    localparam int VM_OUTV    = 4;
    localparam int VM_FLAGS   = 5;
    localparam int VM_LOAD    = 6;
    localparam int VM_INV     = 7;

    // Compound status codes.
    localparam logic [2:0] CODE_OL       = 3'd0;
    localparam logic [2:0] CODE_OL_CHRG  = 3'd1;
    localparam logic [2:0] CODE_OL_LB    = 3'd2;
    localparam logic [2:0] CODE_OB       = 3'd3;
    localparam logic [2:0] CODE_OB_LB    = 3'd4;

    // Model hints held in the configuration register.
    localparam logic [1:0] MODEL_FIRST  = 2'd1;
    localparam logic [1:0] MODEL_SECOND = 2'd2;

    // Flag word bits.
    localparam int FLAG_ON_MAINS = 3;
    localparam int FLAG_LOW_BATT = 1;

    // Datapath widths and limits.
    localparam int MV_W    = 18;
    localparam int SCALE_W = 17;
    localparam int RAW_W   = 16;
    localparam int PROD_W  = RAW_W + SCALE_W;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] OUT_SCALE_N = 3'd7;
    localparam logic [IDX_W-1:0] IN_SCALE_N  = 3'd4;

    localparam logic [RAW_W-1:0] BATT_RAW_MIN = 16'd800;
    localparam logic [RAW_W-1:0] BATT_RAW_MAX = 16'd20000;
    localparam logic [MV_W-1:0]  STABLE_WINDOW_MV = 18'd5000;
    localparam logic [7:0]       STABLE_COUNT_MAX = 8'd255;

    // Plausible AC windows in millivolts (90 V to 150 V, 200 V to 260 V).
    localparam logic [PROD_W-1:0] AC_LO_MIN = 33'd90000;
    localparam logic [PROD_W-1:0] AC_LO_MAX = 33'd150999;
    localparam logic [PROD_W-1:0] AC_HI_MIN = 33'd200000;
    localparam logic [PROD_W-1:0] AC_HI_MAX = 33'd260999;

    // Scale tables: output voltage scales in trial order, then input voltage scales.
    function automatic logic [SCALE_W-1:0] scale_of(input logic out_loop,
                                                    input logic [IDX_W-1:0] idx);
        logic [SCALE_W-1:0] s;
        s = '0;
        if (out_loop) begin
            case (idx)
                3'd0:    s = 17'd1000;
                3'd1:    s = 17'd100;
                3'd2:    s = 17'd10;
                3'd3:    s = 17'd20000;
                3'd4:    s = 17'd10000;
                3'd5:    s = 17'd5000;
                3'd6:    s = 17'd2000;
                default: s = '0;
            endcase
        end else begin
            case (idx)
                3'd0:    s = 17'd1000;
                3'd1:    s = 17'd10000;
                3'd2:    s = 17'd20000;
                3'd3:    s = 17'd120000;
                default: s = '0;
            endcase
        end
        return s;
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } uhd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
    } uhd_sts_t;

endpackage

### design/uhd_ctrl.sv
// Sequencer: takes a report, runs the scale loop, then hands the result over.
module uhd_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  uhd_pkg::uhd_sts_t sts,
    output uhd_pkg::uhd_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_PUB  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_vld_reg, out_vld_next;
    logic       can_publish;

    // The result register is free when empty or being drained this cycle.
    assign can_publish = !out_vld_reg || m_tready;

    // Next state and commands.
    always_comb begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.publish = 1'b0;
        s_tready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                if (sts.done) begin
                    state_next = S_PUB;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_PUB: begin
                if (can_publish) begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output valid flag follows publish and downstream transfers.
    always_comb begin
        out_vld_next = out_vld_reg;
        if (cmd.publish) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign m_tvalid = out_vld_reg;

endmodule

### design/uhd_datapath.sv
// Datapath: report decode, scale multiplier, stability tracker and result register.
module uhd_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  uhd_pkg::uhd_cmd_t cmd,
    output uhd_pkg::uhd_sts_t sts,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_wr_data,
    input  logic [6:0]        in_len,
    input  logic [7:0]        in_id,
    input  logic [7:0]        in_b1,
    input  logic [7:0]        in_b2,
    input  logic [7:0]        in_b3,
    input  logic [7:0]        in_b4,
    output logic [127:0]      res_data,
    output logic [8:0]        res_user
);

    localparam int MV_W   = uhd_pkg::MV_W;
    localparam int PROD_W = uhd_pkg::PROD_W;
    localparam int RAW_W  = uhd_pkg::RAW_W;
    localparam int IDX_W  = uhd_pkg::IDX_W;

    // Configuration register.
    logic [1:0] model_reg;

    // Working result fields.
    logic            rec_reg, rec_next;
    logic [7:0]      mask_reg, mask_next;
    logic [7:0]      charge_reg, charge_next;
    logic [15:0]     runtime_reg, runtime_next;
    logic [MV_W-1:0] battv_reg, battv_next;
    logic            util_reg, util_next;
    logic [MV_W-1:0] outv_reg, outv_next;
    logic [31:0]     flags_reg, flags_next;
    logic [6:0]      load_reg, load_next;
    logic [MV_W-1:0] inv_reg, inv_next;
    logic [2:0]      code_reg, code_next;

    // Scale loop.
    logic              out_loop_reg, out_loop_next;
    logic [RAW_W-1:0]  raw_reg, raw_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              prod_vld_reg, prod_vld_next;
    logic              stop_reg, stop_next;

    // Stability tracker.
    logic            trk_valid_reg, trk_valid_next;
    logic [MV_W-1:0] trk_last_reg, trk_last_next;
    logic [7:0]      trk_count_reg, trk_count_next;

    // Published result.
    logic [127:0] res_data_reg;
    logic [8:0]   res_user_reg;

    // Evaluation of the registered product.
    logic            plaus;
    logic [MV_W-1:0] mv;
    logic [MV_W-1:0] diff;
    logic            near;

    // Decode of the incoming report.
    logic            d_rec;
    logic [7:0]      d_mask;
    logic [7:0]      d_charge;
    logic [15:0]     d_runtime;
    logic [MV_W-1:0] d_battv;
    logic            d_util;
    logic [31:0]     d_flags;
    logic [6:0]      d_load;
    logic [2:0]      d_code;
    logic [IDX_W-1:0] d_cnt;
    logic            d_out_loop;
    logic [RAW_W-1:0] d_raw;
    logic [RAW_W-1:0] batt_raw;

    assign batt_raw = {in_b3, in_b2};

    // Report decode: every field that needs no scale search.
    always_comb begin
        d_rec      = 1'b0;
        d_mask     = '0;
        d_charge   = '0;
        d_runtime  = '0;
        d_battv    = '0;
        d_util     = 1'b0;
        d_flags    = '0;
        d_load     = '0;
        d_code     = uhd_pkg::CODE_OL;
        d_cnt      = '0;
        d_out_loop = 1'b0;
        d_raw      = '0;
        case (in_id)
            uhd_pkg::ID_PRESENT: begin
                d_rec = (in_len >= uhd_pkg::LEN_PRESENT);
            end
            uhd_pkg::ID_BATTERY: begin
                if (in_len >= uhd_pkg::LEN_BATTERY) begin
                    d_rec                      = 1'b1;
                    d_mask[uhd_pkg::VM_CHARGE] = 1'b1;
                    d_charge                   = in_b1;
                    if (model_reg == uhd_pkg::MODEL_FIRST) begin
                        d_mask[uhd_pkg::VM_RUNTIME] = 1'b1;
                        d_runtime                   = batt_raw;
                        if (batt_raw >= uhd_pkg::BATT_RAW_MIN &&
                            batt_raw <= uhd_pkg::BATT_RAW_MAX) begin
                            d_mask[uhd_pkg::VM_BATTV] = 1'b1;
                            // Times ten as eight plus two.
                            d_battv = ({2'b00, batt_raw} << 3) + ({2'b00, batt_raw} << 1);
                        end
                    end else if (model_reg == uhd_pkg::MODEL_SECOND) begin
                        d_mask[uhd_pkg::VM_BATTV] = 1'b1;
                        d_battv                   = {2'b00, batt_raw};
                    end
                end
            end
            uhd_pkg::ID_UTILITY: begin
                if (in_len >= uhd_pkg::LEN_UTILITY) begin
                    d_rec                    = 1'b1;
                    d_mask[uhd_pkg::VM_UTIL] = 1'b1;
                    d_util                   = (in_b1 != 8'd0);
                    d_code = d_util ? uhd_pkg::CODE_OL : uhd_pkg::CODE_OB;
                end
            end
            uhd_pkg::ID_OUT_VOLT: begin
                if (in_len >= uhd_pkg::LEN_OUT_VOLT) begin
                    d_rec      = 1'b1;
                    d_cnt      = uhd_pkg::OUT_SCALE_N;
                    d_out_loop = 1'b1;
                    d_raw      = {in_b2, in_b1};
                end
            end
            uhd_pkg::ID_FLAGS: begin
                if (in_len >= uhd_pkg::LEN_FLAGS) begin
                    d_rec                     = 1'b1;
                    d_mask[uhd_pkg::VM_FLAGS] = 1'b1;
                    d_flags                   = {in_b4, in_b3, in_b2, in_b1};
                    if (in_b1 <= 8'd100) begin
                        d_mask[uhd_pkg::VM_LOAD] = 1'b1;
                        d_load                   = in_b1[6:0];
                    end
                    // Flags decide mains or battery; low battery from its own bit.
                    if (d_flags[uhd_pkg::FLAG_ON_MAINS]) begin
                        d_code = d_flags[uhd_pkg::FLAG_LOW_BATT] ?
                                 uhd_pkg::CODE_OL_LB : uhd_pkg::CODE_OL;
                    end else begin
                        d_code = d_flags[uhd_pkg::FLAG_LOW_BATT] ?
                                 uhd_pkg::CODE_OB_LB : uhd_pkg::CODE_OB;
                    end
                end
            end
            uhd_pkg::ID_IN_VOLT: begin
                if (in_len >= uhd_pkg::LEN_IN_VOLT) begin
                    d_rec = 1'b1;
                    d_cnt = uhd_pkg::IN_SCALE_N;
                    d_raw = {8'h00, in_b1};
                end
            end
            default: d_rec = 1'b0;
        endcase
    end

    // Plausibility and tracker distance of the product from the previous step.
    assign plaus = (prod_reg >= uhd_pkg::AC_LO_MIN && prod_reg <= uhd_pkg::AC_LO_MAX) ||
                   (prod_reg >= uhd_pkg::AC_HI_MIN && prod_reg <= uhd_pkg::AC_HI_MAX);
    assign mv    = prod_reg[MV_W-1:0];
    assign diff  = (trk_last_reg > mv) ? (trk_last_reg - mv) : (mv - trk_last_reg);
    assign near  = (diff <= uhd_pkg::STABLE_WINDOW_MV);

    // The loop is over once a value is taken or every scale has been evaluated.
    assign sts.done = stop_reg || (idx_reg == cnt_reg && !prod_vld_reg);

    // Next values of the working registers and the tracker.
    always_comb begin
        rec_next       = rec_reg;
        mask_next      = mask_reg;
        charge_next    = charge_reg;
        runtime_next   = runtime_reg;
        battv_next     = battv_reg;
        util_next      = util_reg;
        outv_next      = outv_reg;
        flags_next     = flags_reg;
        load_next      = load_reg;
        inv_next       = inv_reg;
        code_next      = code_reg;
        out_loop_next  = out_loop_reg;
        raw_next       = raw_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        prod_next      = prod_reg;
        prod_vld_next  = prod_vld_reg;
        stop_next      = stop_reg;
        trk_valid_next = trk_valid_reg;
        trk_last_next  = trk_last_reg;
        trk_count_next = trk_count_reg;

        if (cmd.load) begin
            rec_next      = d_rec;
            mask_next     = d_mask;
            charge_next   = d_charge;
            runtime_next  = d_runtime;
            battv_next    = d_battv;
            util_next     = d_util;
            outv_next     = '0;
            flags_next    = d_flags;
            load_next     = d_load;
            inv_next      = '0;
            code_next     = d_code;
            out_loop_next = d_out_loop;
            raw_next      = d_raw;
            idx_next      = '0;
            cnt_next      = d_cnt;
            prod_vld_next = 1'b0;
            stop_next     = 1'b0;
        end else if (cmd.step) begin
            // Multiplier stage: next scale times the raw reading.
            if (idx_reg < cnt_reg) begin
                prod_next     = PROD_W'(raw_reg) *
                                PROD_W'(uhd_pkg::scale_of(out_loop_reg, idx_reg));
                prod_vld_next = 1'b1;
                idx_next      = idx_reg + 1'b1;
            end else begin
                prod_vld_next = 1'b0;
            end

            // Evaluation stage on the product registered in the step before.
            if (prod_vld_reg && plaus) begin
                if (out_loop_reg) begin
                    trk_valid_next = 1'b1;
                    trk_last_next  = mv;
                    if (!trk_valid_reg || !near) begin
                        trk_count_next = 8'd1;
                    end else if (trk_count_reg != uhd_pkg::STABLE_COUNT_MAX) begin
                        trk_count_next = trk_count_reg + 8'd1;
                    end
                    // A near repeat always brings the count to two or more.
                    if (trk_valid_reg && near) begin
                        mask_next[uhd_pkg::VM_OUTV] = 1'b1;
                        outv_next                   = mv;
                        stop_next                   = 1'b1;
                    end
                end else begin
                    mask_next[uhd_pkg::VM_INV] = 1'b1;
                    inv_next                   = mv;
                    stop_next                  = 1'b1;
                end
            end
        end
    end

    // Control and tracker state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            model_reg     <= '0;
            trk_valid_reg <= 1'b0;
            trk_last_reg  <= '0;
            trk_count_reg <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            prod_vld_reg  <= 1'b0;
            stop_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                model_reg <= cfg_wr_data;
            end
            trk_valid_reg <= trk_valid_next;
            trk_last_reg  <= trk_last_next;
            trk_count_reg <= trk_count_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            prod_vld_reg  <= prod_vld_next;
            stop_reg      <= stop_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        rec_reg      <= rec_next;
        mask_reg     <= mask_next;
        charge_reg   <= charge_next;
        runtime_reg  <= runtime_next;
        battv_reg    <= battv_next;
        util_reg     <= util_next;
        outv_reg     <= outv_next;
        flags_reg    <= flags_next;
        load_reg     <= load_next;
        inv_reg      <= inv_next;
        code_reg     <= code_next;
        out_loop_reg <= out_loop_next;
        raw_reg      <= raw_next;
        prod_reg     <= prod_next;
        if (cmd.publish) begin
            res_data_reg <= {7'd0, code_reg, inv_reg, load_reg, flags_reg, outv_reg,
                             util_reg, battv_reg, runtime_reg, charge_reg};
            res_user_reg <= {mask_reg, rec_reg};
        end
    end

    assign res_data = res_data_reg;
    assign res_user = res_user_reg;

endmodule

### design/ups_hid_report_decoder.sv
// UPS HID report decoder.
// Input: one report per s_ transfer. s_tuser carries the report id, s_tdata the
// length and report bytes 1 to 4. Output: one result per report on m_, with the
// recognized flag and valid mask in m_tuser and the decoded fields in m_tdata.
// The user must write the model hint via cfg_wr_en/cfg_wr_data only while idle; the
// block does not enforce this. A report is taken while idle; the run state then
// steps the scale loop, one scale trial per cycle (none for most ids, up to 7 for
// the output voltage report, up to 4 for input voltage), each product evaluated on
// the step after it is formed; the publish state then loads the result register
// once it is free. The next report is taken only after the return to idle, so a
// report is not taken before the last one is published. The trial rate is set by
// the shared scale multiplier and the tracker.
// Reset clears the model hint to unknown and empties the voltage stability tracker.
// When the receiver stalls, the finished result waits in the output register; one
// more report is taken and decoded, and it then waits until the register is free.
module ups_hid_report_decoder (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_wr_data,   // model_select
    input  logic         s_tvalid,
    output logic         s_tready,
    // [6:0] report_length, [14:7] byte_one, [22:15] byte_two, [30:23] byte_three,
    // [38:31] byte_four, [39] zero
    input  logic [39:0]  s_tdata,
    input  logic [7:0]   s_tuser,       // [7:0] report_id
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] batt_charge, [23:8] batt_runtime, [41:24] batt_volt_mv,
    // [42] utility_present, [60:43] out_volt_mv, [92:61] status_flags,
    // [99:93] load_percent, [117:100] in_volt_mv, [120:118] status_code,
    // [127:121] zero
    output logic [127:0] m_tdata,
    output logic [8:0]   m_tuser        // [0] recognized, [8:1] valid_mask
);

    uhd_pkg::uhd_cmd_t cmd;
    uhd_pkg::uhd_sts_t sts;

    // Sequencer.
    uhd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Decode and tracking datapath.
    uhd_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_len      (s_tdata[6:0]),
        .in_id       (s_tuser),
        .in_b1       (s_tdata[14:7]),
        .in_b2       (s_tdata[22:15]),
        .in_b3       (s_tdata[30:23]),
        .in_b4       (s_tdata[38:31]),
        .res_data    (m_tdata),
        .res_user    (m_tuser)
    );

endmodule
